// ===== hdl/egsp_pkg.sv =====
// ----------------------------------------------------------------------------
// egsp_pkg
// Shared types and constants for the Euclidean graph shortest path engine.
// ----------------------------------------------------------------------------
package egsp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_DEGREE   = 16;
    localparam int COORD_BITS   = 16;

    localparam int VX_W     = 6;
    localparam int VCNT_W   = 7;
    localparam int DIST_W   = 24;
    localparam int CNT_W    = $clog2(MAX_DEGREE + 1);
    localparam int NB_AW    = $clog2(MAX_VERTICES * MAX_DEGREE);
    localparam int IDX_W    = $clog2(MAX_VERTICES + 1);
    localparam int LEN_W    = $clog2(MAX_VERTICES + 1);
    localparam int SQ_W     = 2 * COORD_BITS + 1;
    localparam int ROOT_W   = COORD_BITS + 1;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int STEP_W   = $clog2(ROOT_W + 1);
    localparam int MAX_PATH = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_EDGE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef enum logic [1:0] {
        ST_PATH    = 2'd0,
        ST_UNREACH = 2'd1,
        ST_BAD     = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_CNTA, S_CNTB, S_EDGE2,
        S_SCAN, S_UCNT, S_NB, S_NBW, S_VCHK, S_VRD,
        S_MUL1, S_MUL2, S_SQST, S_SQRT, S_UPD,
        S_FIN, S_FIN2, S_PUSH, S_PRED, S_OUT, S_ORD, S_ERR
    } t_state;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

    function automatic logic [NB_AW-1:0] nb_addr(logic [VX_W-1:0] v, logic [CNT_W-1:0] n);
        return NB_AW'(NB_AW'(v) * NB_AW'(MAX_DEGREE) + NB_AW'(n));
    endfunction

endpackage

// ===== hdl/egsp_isqrt.sv =====
// ----------------------------------------------------------------------------
// egsp_isqrt
// Restoring integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module egsp_isqrt import egsp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sqrt_req i_req,
    output t_sqrt_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [RAD_W-1:0]  r_rad,  n_rad;
    logic [ROOT_W+1:0] r_rem,  n_rem;
    logic [ROOT_W-1:0] r_root, n_root;

    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              ge;

    always_comb begin
        rem_sh = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
        trial  = {r_root, 2'b01};
        ge     = (rem_sh >= trial);
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(ROOT_W);
            n_rad  = RAD_W'(i_req.radicand);
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad  = {r_rad[RAD_W-3:0], 2'b00};
            n_rem  = ge ? (rem_sh - trial) : rem_sh;
            n_root = {r_root[ROOT_W-2:0], ge};
            n_step = r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("root done while still busy");
    a_busy_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step != '0)) else $error("busy with no steps left");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy) else $error("start did not launch");
`endif

endmodule

// ===== hdl/euclidean_graph_shortest_path_top.sv =====
// Sequence: a load is written as it is accepted; an edge add passes S_CHK, S_CNTA,
// S_CNTB and S_EDGE2 before ready returns. An error word leaves from S_ERR, entered
// from S_IDLE on a bad load, via S_CHK on a bad edge or query, and via S_CHK, S_CNTA
// and S_CNTB on a full edge. Query: a sweep over best_distance (one entry a cycle)
// per settled vertex, a bit-serial square root per neighbour relaxed, then the path trace
// and path words. One item at a time. Reset: control state and valid bits clear; no clearing pass.
// ----------------------------------------------------------------------------
// euclidean_graph_shortest_path_top
// Graph store, Dijkstra sequencer and result output register.
// ----------------------------------------------------------------------------
module euclidean_graph_shortest_path_top import egsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [VCNT_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_opcode,
    input  logic [VX_W-1:0]   i_vertex_a,
    input  logic [VX_W-1:0]   i_vertex_b,
    input  logic [15:0]       i_x_coord,
    input  logic [15:0]       i_y_coord,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic [VX_W-1:0]   o_vertex,
    output logic [DIST_W-1:0] o_total_distance,
    output logic              o_last
);

    localparam int CW = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

    t_state r_state, n_state;
    logic [VCNT_W-1:0]       r_vcount;
    logic [MAX_VERTICES-1:0] r_loaded, n_loaded;
    logic [MAX_VERTICES-1:0] r_known, n_known;
    logic [MAX_VERTICES-1:0] r_settled, n_settled;
    logic [MAX_VERTICES-1:0] r_cnt_vld, n_cnt_vld;
    logic                    r_o_valid, n_o_valid;

    logic [1:0]            r_op, n_op;
    logic [VX_W-1:0]       r_a, n_a, r_b, n_b;
    logic [CNT_W-1:0]      r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b, r_cnt_u, n_cnt_u;
    logic [CNT_W-1:0]      r_n, n_n;
    logic [VX_W-1:0]       r_u, n_u, r_pi, n_pi, r_v, n_v, r_pu, n_pu, r_ev, n_ev;
    logic [DIST_W-1:0]     r_ud, n_ud, r_vbest, n_vbest, r_w, n_w, r_total, n_total;
    logic                  r_found, n_found, r_pv, n_pv;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [COORD_BITS-1:0] r_ux, n_ux, r_uy, n_uy, r_dx, n_dx, r_dy, n_dy;
    logic [SQ_W-1:0]       r_sq, n_sq;
    t_status               r_est, n_est;
    t_status               r_o_status, n_o_status;
    logic [VX_W-1:0]       r_o_vertex, n_o_vertex;
    logic [DIST_W-1:0]     r_o_dist, n_o_dist;
    logic                  r_o_last, n_o_last;

    // storage
    logic [COORD_BITS-1:0] r_x_mem [MAX_VERTICES];
    logic [COORD_BITS-1:0] r_y_mem [MAX_VERTICES];
    logic [VX_W-1:0]       r_nb_mem [MAX_VERTICES*MAX_DEGREE];
    logic [CNT_W-1:0]      r_cnt_mem [MAX_VERTICES];
    logic [DIST_W-1:0]     r_best_mem [MAX_VERTICES];
    logic [VX_W-1:0]       r_pred_mem [MAX_VERTICES];
    logic [VX_W-1:0]       r_stk_mem [MAX_VERTICES];

    logic                  xy_we, xy_re;
    logic [VX_W-1:0]       xy_wa, xy_ra;
    logic [COORD_BITS-1:0] x_wd, y_wd, r_x_rd, r_y_rd;
    logic                  nb_we, nb_re;
    logic [NB_AW-1:0]      nb_wa, nb_ra;
    logic [VX_W-1:0]       nb_wd, r_nb_rd;
    logic                  cnt_we, cnt_re;
    logic [VX_W-1:0]       cnt_wa, cnt_ra;
    logic [CNT_W-1:0]      cnt_wd, r_cnt_rd;
    logic                  best_we, best_re;
    logic [VX_W-1:0]       best_wa, best_ra;
    logic [DIST_W-1:0]     best_wd, r_best_rd;
    logic                  pred_we, pred_re;
    logic [VX_W-1:0]       pred_wa, pred_ra, pred_wd, r_pred_rd;
    logic                  stk_we, stk_re;
    logic [VX_W-1:0]       stk_wa, stk_ra, stk_wd, r_stk_rd;

    t_sqrt_req sq_req;
    t_sqrt_rsp sq_rsp;

    logic                    slot_free;
    logic                    va_ok, vb_ok, vv_ok;
    logic [COORD_BITS-1:0]   mul_a;
    logic [2*COORD_BITS-1:0] prod;
    logic [CNT_W-1:0]        cnt_b_cur, cnt_b_use;
    logic                    full;
    logic [DIST_W:0]         nd_sum;
    logic [DIST_W-1:0]       nd;
    logic                    cand;

    egsp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    assign va_ok = ({1'b0, r_a} < r_vcount) && (int'(r_a) < MAX_VERTICES) && r_loaded[r_a];
    assign vb_ok = ({1'b0, r_b} < r_vcount) && (int'(r_b) < MAX_VERTICES) && r_loaded[r_b];
    assign vv_ok = ({1'b0, r_v} < r_vcount) && (int'(r_v) < MAX_VERTICES) && r_loaded[r_v];

    // one shared multiplier squares dx then dy
    assign mul_a = (r_state == S_MUL1) ? r_dx : r_dy;
    assign prod  = (2*COORD_BITS)'(mul_a) * (2*COORD_BITS)'(mul_a);

    assign slot_free = !r_o_valid || i_out_ready;
    assign nd_sum    = {1'b0, r_ud} + {1'b0, r_w};
    assign nd        = nd_sum[DIST_W] ? DIST_MAX : nd_sum[DIST_W-1:0];
    assign cnt_b_cur = r_cnt_vld[r_b] ? r_cnt_rd : '0;
    assign cnt_b_use = (r_a == r_b) ? (r_cnt_a + CNT_W'(1)) : r_cnt_b;
    assign full = (r_a == r_b && ((CNT_W+1)'(r_cnt_a) + (CNT_W+1)'(2) > (CNT_W+1)'(MAX_DEGREE)))
                  || ((CNT_W+1)'(r_cnt_a) >= (CNT_W+1)'(MAX_DEGREE))
                  || ((CNT_W+1)'(cnt_b_cur) >= (CNT_W+1)'(MAX_DEGREE));
    assign cand = r_known[r_pi] && !r_settled[r_pi] && (!r_found || r_best_rd < r_ud);

    always_comb begin
        n_state = r_state;   n_loaded = r_loaded;  n_known = r_known;
        n_settled = r_settled; n_cnt_vld = r_cnt_vld; n_o_valid = r_o_valid;
        n_op = r_op; n_a = r_a; n_b = r_b; n_cnt_a = r_cnt_a; n_cnt_b = r_cnt_b;
        n_cnt_u = r_cnt_u; n_n = r_n; n_u = r_u; n_pi = r_pi; n_v = r_v; n_pu = r_pu;
        n_ev = r_ev; n_ud = r_ud; n_vbest = r_vbest; n_w = r_w; n_total = r_total;
        n_found = r_found; n_pv = r_pv; n_idx = r_idx; n_len = r_len;
        n_ux = r_ux; n_uy = r_uy; n_dx = r_dx; n_dy = r_dy; n_sq = r_sq; n_est = r_est;
        n_o_status = r_o_status; n_o_vertex = r_o_vertex; n_o_dist = r_o_dist;
        n_o_last = r_o_last;
        o_in_ready = 1'b0;
        xy_we = 1'b0; xy_re = 1'b0; xy_wa = i_vertex_a; xy_ra = r_u;
        x_wd = COORD_BITS'(i_x_coord); y_wd = COORD_BITS'(i_y_coord);
        nb_we = 1'b0; nb_re = 1'b0; nb_wa = nb_addr(r_a, r_cnt_a); nb_wd = r_b;
        nb_ra = nb_addr(r_u, r_n);
        cnt_we = 1'b0; cnt_re = 1'b0; cnt_wa = r_a; cnt_wd = r_cnt_a + CNT_W'(1);
        cnt_ra = r_a;
        best_we = 1'b0; best_re = 1'b0; best_wa = r_v; best_wd = nd; best_ra = r_v;
        pred_we = 1'b0; pred_re = 1'b0; pred_wa = r_v; pred_wd = r_u; pred_ra = r_pu;
        stk_we = 1'b0; stk_re = 1'b0; stk_wa = r_len[VX_W-1:0]; stk_wd = r_pu;
        stk_ra = VX_W'(r_len - LEN_W'(1));
        sq_req.start = 1'b0; sq_req.radicand = r_sq;

        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_a  = i_vertex_a;
                    n_b  = i_vertex_b;
                    n_op = i_opcode;
                    case (i_opcode) inside
                        OP_LOAD: begin
                            if ({1'b0, i_vertex_a} < r_vcount
                                && int'(i_vertex_a) < MAX_VERTICES) begin
                                xy_we = 1'b1;
                                n_loaded[i_vertex_a] = 1'b1;
                            end else begin
                                n_est   = ST_BAD;
                                n_ev    = i_vertex_a;
                                n_state = S_ERR;
                            end
                        end
                        OP_EDGE, OP_QUERY: n_state = S_CHK;
                        default: ;
                    endcase
                end
            end
            S_CHK: begin
                if (!(va_ok && vb_ok)) begin
                    n_est   = ST_BAD;
                    n_ev    = r_b;
                    n_state = S_ERR;
                end else if (r_op == OP_EDGE) begin
                    cnt_re  = 1'b1;
                    n_state = S_CNTA;
                end else begin
                    n_known        = '0;
                    n_known[r_a]   = 1'b1;
                    n_settled      = '0;
                    best_we        = 1'b1;
                    best_wa        = r_a;
                    best_wd        = '0;
                    n_idx          = '0;
                    n_pv           = 1'b0;
                    n_found        = 1'b0;
                    n_state        = S_SCAN;
                end
            end
            S_CNTA: begin
                n_cnt_a = r_cnt_vld[r_a] ? r_cnt_rd : '0;
                cnt_re  = 1'b1;
                cnt_ra  = r_b;
                n_state = S_CNTB;
            end
            S_CNTB: begin
                n_cnt_b = cnt_b_cur;
                if (full) begin
                    n_est   = ST_FULL;
                    n_ev    = r_b;
                    n_state = S_ERR;
                end else begin
                    nb_we            = 1'b1;
                    cnt_we           = 1'b1;
                    n_cnt_vld[r_a]   = 1'b1;
                    n_state          = S_EDGE2;
                end
            end
            S_EDGE2: begin
                nb_we          = 1'b1;
                nb_wa          = nb_addr(r_b, cnt_b_use);
                nb_wd          = r_a;
                cnt_we         = 1'b1;
                cnt_wa         = r_b;
                cnt_wd         = cnt_b_use + CNT_W'(1);
                n_cnt_vld[r_b] = 1'b1;
                n_state        = S_IDLE;
            end
            S_SCAN: begin
                // read data lands in the cycle after its sweep index is issued
                if (r_pv && cand) begin
                    n_u     = r_pi;
                    n_ud    = r_best_rd;
                    n_found = 1'b1;
                end
                if (r_idx != IDX_W'(MAX_VERTICES)) begin
                    best_re = 1'b1;
                    best_ra = r_idx[VX_W-1:0];
                    n_pv    = 1'b1;
                    n_pi    = r_idx[VX_W-1:0];
                    n_idx   = r_idx + IDX_W'(1);
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        if (!r_found) begin
                            n_state = S_FIN;
                        end else begin
                            n_settled[r_u] = 1'b1;
                            cnt_re         = 1'b1;
                            cnt_ra         = r_u;
                            xy_re          = 1'b1;
                            n_state        = S_UCNT;
                        end
                    end
                end
            end
            S_UCNT: begin
                n_cnt_u = r_cnt_vld[r_u] ? r_cnt_rd : '0;
                n_ux    = r_x_rd;
                n_uy    = r_y_rd;
                n_n     = '0;
                n_state = S_NB;
            end
            S_NB: begin
                if (r_n >= r_cnt_u) begin
                    n_idx   = '0;
                    n_pv    = 1'b0;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    nb_re   = 1'b1;
                    n_state = S_NBW;
                end
            end
            S_NBW: begin
                n_v     = r_nb_rd;
                n_state = S_VCHK;
            end
            S_VCHK: begin
                if (!vv_ok) begin
                    n_n     = r_n + CNT_W'(1);
                    n_state = S_NB;
                end else begin
                    xy_re   = 1'b1;
                    xy_ra   = r_v;
                    best_re = 1'b1;
                    n_state = S_VRD;
                end
            end
            S_VRD: begin
                n_vbest = r_best_rd;
                n_dx    = (r_x_rd > r_ux) ? (r_x_rd - r_ux) : (r_ux - r_x_rd);
                n_dy    = (r_y_rd > r_uy) ? (r_y_rd - r_uy) : (r_uy - r_y_rd);
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_sq    = SQ_W'(prod);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_sq    = r_sq + SQ_W'(prod);
                n_state = S_SQST;
            end
            S_SQST: begin
                sq_req.start = 1'b1;
                n_state      = S_SQRT;
            end
            S_SQRT: begin
                if (sq_rsp.done) begin
                    n_w = (CW'(sq_rsp.root) > CW'(DIST_MAX)) ? DIST_MAX
                                                             : DIST_W'(sq_rsp.root);
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                // relax on strict improvement only
                if (!r_known[r_v] || nd < r_vbest) begin
                    best_we      = 1'b1;
                    pred_we      = 1'b1;
                    n_known[r_v] = 1'b1;
                end
                n_n     = r_n + CNT_W'(1);
                n_state = S_NB;
            end
            S_FIN: begin
                best_re = 1'b1;
                best_ra = r_b;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                if (!r_known[r_b]) begin
                    n_est   = ST_UNREACH;
                    n_ev    = r_b;
                    n_state = S_ERR;
                end else begin
                    n_total = r_best_rd;
                    n_pu    = r_b;
                    n_len   = '0;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                stk_we = 1'b1;
                n_len  = r_len + LEN_W'(1);
                if (r_pu == r_a || r_len == LEN_W'(MAX_PATH - 1)) begin
                    n_state = S_OUT;
                end else begin
                    pred_re = 1'b1;
                    n_state = S_PRED;
                end
            end
            S_PRED: begin
                n_pu    = r_pred_rd;
                n_state = S_PUSH;
            end
            S_OUT: begin
                stk_re  = 1'b1;
                n_state = S_ORD;
            end
            S_ORD: begin
                if (slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = ST_PATH;
                    n_o_vertex = r_stk_rd;
                    n_o_dist   = r_total;
                    n_o_last   = (r_len == LEN_W'(1));
                    n_len      = r_len - LEN_W'(1);
                    if (r_len == LEN_W'(1)) begin
                        n_known   = '0;
                        n_settled = '0;
                        n_state   = S_IDLE;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_ERR: begin
                if (slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_est;
                    n_o_vertex = r_ev;
                    n_o_dist   = '0;
                    n_o_last   = 1'b1;
                    n_known    = '0;
                    n_settled  = '0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vcount  <= VCNT_W'(MAX_VERTICES);
            r_loaded  <= '0;
            r_known   <= '0;
            r_settled <= '0;
            r_cnt_vld <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            r_loaded  <= n_loaded;
            r_known   <= n_known;
            r_settled <= n_settled;
            r_cnt_vld <= n_cnt_vld;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_a <= n_a; r_b <= n_b; r_cnt_a <= n_cnt_a; r_cnt_b <= n_cnt_b;
        r_cnt_u <= n_cnt_u; r_n <= n_n; r_u <= n_u; r_pi <= n_pi; r_v <= n_v;
        r_pu <= n_pu; r_ev <= n_ev; r_ud <= n_ud; r_vbest <= n_vbest; r_w <= n_w;
        r_total <= n_total; r_found <= n_found; r_pv <= n_pv; r_idx <= n_idx;
        r_len <= n_len; r_ux <= n_ux; r_uy <= n_uy; r_dx <= n_dx; r_dy <= n_dy;
        r_sq <= n_sq; r_est <= n_est;
        r_o_status <= n_o_status; r_o_vertex <= n_o_vertex;
        r_o_dist <= n_o_dist; r_o_last <= n_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (xy_we) begin
            r_x_mem[xy_wa] <= x_wd;
            r_y_mem[xy_wa] <= y_wd;
        end
        if (xy_re) begin
            r_x_rd <= r_x_mem[xy_ra];
            r_y_rd <= r_y_mem[xy_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (nb_we) begin
            r_nb_mem[nb_wa] <= nb_wd;
        end
        if (nb_re) begin
            r_nb_rd <= r_nb_mem[nb_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cnt_re) begin
            r_cnt_rd <= r_cnt_mem[cnt_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (best_we) begin
            r_best_mem[best_wa] <= best_wd;
        end
        if (best_re) begin
            r_best_rd <= r_best_mem[best_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pred_we) begin
            r_pred_mem[pred_wa] <= pred_wd;
        end
        if (pred_re) begin
            r_pred_rd <= r_pred_mem[pred_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_wa] <= stk_wd;
        end
        if (stk_re) begin
            r_stk_rd <= r_stk_mem[stk_ra];
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_status         = r_o_status;
    assign o_vertex         = r_o_vertex;
    assign o_total_distance = r_o_dist;
    assign o_last           = r_o_last;

`ifndef ASSERT_OFF
    a_settled_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_settled & ~r_known) == '0) else $error("settled vertex without distance");
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_known == '0)) else $error("search state not cleared");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != ST_PATH) |-> r_o_last)
        else $error("error word not marked last");
`endif

endmodule

// ===== test/euclidean_graph_shortest_path_checker.sv =====
// ----------------------------------------------------------------------------
// euclidean_graph_shortest_path_checker
// Watches the command and result channels of the shortest path engine, keeps
// its own copy of the graph and vertex_count, runs Dijkstra on each accepted
// query and compares every result word field by field with the oldest one due.
// ----------------------------------------------------------------------------
module euclidean_graph_shortest_path_checker import egsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [VCNT_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [1:0]        i_opcode,
    input  logic [VX_W-1:0]   i_vertex_a,
    input  logic [VX_W-1:0]   i_vertex_b,
    input  logic [15:0]       i_x_coord,
    input  logic [15:0]       i_y_coord,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [1:0]        i_status,
    input  logic [VX_W-1:0]   i_vertex,
    input  logic [DIST_W-1:0] i_total_distance,
    input  logic              i_last,
    output int                o_errors,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]        status;
        logic [VX_W-1:0]   vertex;
        logic [DIST_W-1:0] total;
        logic              last;
    } t_route_word;

    t_route_word        due_words[$];
    logic [15:0]        pos_x [MAX_VERTICES];
    logic [15:0]        pos_y [MAX_VERTICES];
    bit                 present [MAX_VERTICES];
    logic [VX_W-1:0]    adjacency [MAX_VERTICES][MAX_DEGREE];
    int                 degree [MAX_VERTICES];
    int                 vertex_count;
    int                 errors;

    function automatic bit usable(int v);
        return v < vertex_count && v < MAX_VERTICES && present[v];
    endfunction

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int i = 17; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    function automatic longint unsigned span(int u, int v);
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned w;
        dx = pos_x[u] > pos_x[v] ? pos_x[u] - pos_x[v] : pos_x[v] - pos_x[u];
        dy = pos_y[u] > pos_y[v] ? pos_y[u] - pos_y[v] : pos_y[v] - pos_y[u];
        w = floor_root(dx * dx + dy * dy);
        return w > DIST_MAX ? DIST_MAX : w;
    endfunction

    function automatic void post(t_status s, int v, longint unsigned d, bit last);
        t_route_word w;
        w.status = s;
        w.vertex = v[VX_W-1:0];
        w.total  = d[DIST_W-1:0];
        w.last   = last;
        due_words.push_back(w);
    endfunction

    function automatic void route(int a, int b);
        longint unsigned reach [MAX_VERTICES];
        bit              known [MAX_VERTICES];
        bit              done [MAX_VERTICES];
        int              from [MAX_VERTICES];
        int              trail[$];
        int              u;
        int              v;
        bit              found;
        longint unsigned nd;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            known[i] = 0;
            done[i]  = 0;
            reach[i] = 0;
            from[i]  = 0;
        end
        reach[a] = 0;
        known[a] = 1;
        forever begin
            found = 0;
            u = 0;
            for (int i = 0; i < MAX_VERTICES; i++)
                if (known[i] && !done[i] && (!found || reach[i] < reach[u])) begin
                    u = i;
                    found = 1;
                end
            if (!found) break;
            done[u] = 1;
            for (int n = 0; n < degree[u]; n++) begin
                v = adjacency[u][n];
                // neighbours past a shrunk vertex_count drop out of the search
                if (!usable(v)) continue;
                nd = reach[u] + span(u, v);
                if (nd > DIST_MAX) nd = DIST_MAX;
                if (!known[v] || nd < reach[v]) begin
                    reach[v] = nd;
                    known[v] = 1;
                    from[v]  = u;
                end
            end
        end
        if (!known[b]) begin
            post(ST_UNREACH, b, 0, 1);
            return;
        end
        u = b;
        trail.push_front(u);
        while (u != a && trail.size() < 64) begin
            u = from[u];
            trail.push_front(u);
        end
        foreach (trail[k]) post(ST_PATH, trail[k], reach[b], k == trail.size() - 1);
    endfunction

    function automatic void apply_command(logic [1:0] op, int a, int b, logic [15:0] x,
                                          logic [15:0] y);
        case (op)
            OP_LOAD: begin
                if (a >= vertex_count) post(ST_BAD, a, 0, 1);
                else begin
                    pos_x[a]   = x;
                    pos_y[a]   = y;
                    present[a] = 1;
                end
            end
            OP_EDGE: begin
                if (!usable(a) || !usable(b)) post(ST_BAD, b, 0, 1);
                else if ((a == b && degree[a] + 2 > MAX_DEGREE) ||
                         degree[a] >= MAX_DEGREE || degree[b] >= MAX_DEGREE)
                    post(ST_FULL, b, 0, 1);
                else begin
                    adjacency[a][degree[a]] = b;
                    degree[a]++;
                    adjacency[b][degree[b]] = a;
                    degree[b]++;
                end
            end
            OP_QUERY: begin
                if (!usable(a) || !usable(b)) post(ST_BAD, b, 0, 1);
                else route(a, b);
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_route_word seen;
        t_route_word want;
        if (!i_rst_n) begin
            vertex_count = MAX_VERTICES;
            for (int i = 0; i < MAX_VERTICES; i++) begin
                present[i] = 0;
                degree[i]  = 0;
            end
            due_words.delete();
            errors = 0;
        end else begin
            // results first: a word leaving now belongs to an earlier command
            if (i_out_valid && i_out_ready) begin
                seen = {i_status, i_vertex, i_total_distance, i_last};
                if (due_words.size() == 0) begin
                    $display("%0t: unexpected result word status=%0d vertex=%0d dist=%0d last=%0b",
                             $realtime, i_status, i_vertex, i_total_distance, i_last);
                    errors++;
                end else begin
                    want = due_words.pop_front();
                    if (seen.status != want.status || seen.vertex != want.vertex ||
                        seen.total != want.total || seen.last != want.last) begin
                        $display("%0t: mismatch expected status=%0d vertex=%0d dist=%0d last=%0b",
                                 $realtime, want.status, want.vertex, want.total, want.last);
                        $display("%0t:          actual   status=%0d vertex=%0d dist=%0d last=%0b",
                                 $realtime, seen.status, seen.vertex, seen.total, seen.last);
                        errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                apply_command(i_opcode, i_vertex_a, i_vertex_b, i_x_coord, i_y_coord);
            if (i_cfg_we) vertex_count = i_cfg_data;
        end
        o_errors  <= errors;
        o_pending <= due_words.size();
    end

endmodule

// ===== test/euclidean_graph_shortest_path_top_test.sv =====
// ----------------------------------------------------------------------------
// euclidean_graph_shortest_path_top_test
// Drives graph loads, edges and path queries into the engine under several
// vertex_count settings and handshake idling patterns; the checker predicts
// and compares every result word, and this module gives the verdict.
// ----------------------------------------------------------------------------
module euclidean_graph_shortest_path_top_test;
    import egsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int         CYCLE_LIMIT = 40000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [VCNT_W-1:0] i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_opcode;
    logic [VX_W-1:0]   i_vertex_a;
    logic [VX_W-1:0]   i_vertex_b;
    logic [15:0]       i_x_coord;
    logic [15:0]       i_y_coord;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [1:0]        o_status;
    logic [VX_W-1:0]   o_vertex;
    logic [DIST_W-1:0] o_total_distance;
    logic              o_last;
    int                errors;
    int                pending;
    int                send_idle;
    int                take_idle;
    int                cycles = 0;

    euclidean_graph_shortest_path_top u_dut (.*);

    euclidean_graph_shortest_path_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready),
        .i_opcode, .i_vertex_a, .i_vertex_b, .i_x_coord, .i_y_coord,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_status(o_status), .i_vertex(o_vertex),
        .i_total_distance(o_total_distance), .i_last(o_last),
        .o_errors(errors), .o_pending(pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= take_idle);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("euclidean_graph_shortest_path_top_test NOT OK");
            $finish;
        end
    end

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_word(input logic [1:0] op, input int a, input int b,
                             input logic [15:0] x, input logic [15:0] y);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_vertex_a <= a[VX_W-1:0];
        i_vertex_b <= b[VX_W-1:0];
        i_x_coord  <= x;
        i_y_coord  <= y;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
    endtask

    // hold off until every result is in, plus time for a silent load or edge
    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(input int n);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n[VCNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int pick_vertex(int hi);
        return ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(hi);
    endfunction

    function automatic logic [15:0] pick_coord;
        return ($urandom_range(2) == 0) ? 16'($urandom_range(255)) : 16'($urandom);
    endfunction

    task automatic random_words(input int count, input int hi);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 40)
                send_word(OP_LOAD, pick_vertex(hi), $urandom_range(63), pick_coord(),
                          pick_coord());
            else if (r < 75)
                send_word(OP_EDGE, pick_vertex(hi), pick_vertex(hi), 16'($urandom),
                          16'($urandom));
            else if (r < 95)
                send_word(OP_QUERY, pick_vertex(hi), pick_vertex(hi), 16'($urandom),
                          16'($urandom));
            else
                send_word(OP_IGNORED, $urandom_range(63), $urandom_range(63),
                          16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_opcode    = OP_LOAD;
        i_vertex_a  = '0;
        i_vertex_b  = '0;
        i_x_coord   = '0;
        i_y_coord   = '0;
        send_idle   = 33;
        take_idle   = 58;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty graph, corner coordinates, self edge, reload, unreachable
        send_word(OP_QUERY, 0, 0, 16'h0000, 16'h0000);
        send_word(OP_LOAD, 0, 0, 16'h0000, 16'h0000);
        send_word(OP_LOAD, 63, 0, 16'hffff, 16'hffff);
        send_word(OP_LOAD, 1, 0, 16'hffff, 16'h0000);
        send_word(OP_EDGE, 0, 2, 16'h0000, 16'h0000);
        send_word(OP_EDGE, 0, 1, 16'h0000, 16'h0000);
        send_word(OP_EDGE, 1, 63, 16'h0000, 16'h0000);
        send_word(OP_QUERY, 0, 63, 16'h0000, 16'h0000);
        send_word(OP_QUERY, 0, 0, 16'h0000, 16'h0000);
        send_word(OP_LOAD, 2, 0, 16'h0003, 16'h0004);
        send_word(OP_QUERY, 0, 2, 16'h0000, 16'h0000);
        send_word(OP_EDGE, 2, 2, 16'h0000, 16'h0000);
        send_word(OP_LOAD, 2, 0, 16'h0000, 16'h0005);
        send_word(OP_EDGE, 0, 2, 16'h0000, 16'h0000);
        send_word(OP_QUERY, 63, 2, 16'h0000, 16'h0000);
        send_word(OP_IGNORED, 63, 63, 16'hffff, 16'hffff);
        send_word(OP_QUERY, 0, 50, 16'h0000, 16'h0000);
        send_word(OP_LOAD, 62, 63, 16'h5555, 16'haaaa);
        send_word(OP_EDGE, 62, 63, 16'haaaa, 16'h5555);
        send_word(OP_QUERY, 62, 0, 16'h0000, 16'h0000);
        random_words(90, 11);

        drain();
        set_vertex_count(1);
        random_words(20, 3);

        drain();
        send_idle = 58;
        take_idle = 33;
        set_vertex_count(8);
        random_words(70, 15);

        drain();
        send_idle = 0;
        take_idle = 0;
        set_vertex_count(64);
        random_words(100, 20);

        drain();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("euclidean_graph_shortest_path_top_test OK");
        else
            $display("euclidean_graph_shortest_path_top_test NOT OK");
        $finish;
    end

endmodule
